>>> src/rrmd_pkg.sv
package rrmd_pkg;

    // Stream payload widths, padded to whole bytes
    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    localparam int SIZE_W  = 6;
    localparam int TOP_W   = 12;
    localparam int X_W     = 16;
    localparam int Y_W     = 14;
    localparam int SHIFT_W = 10;

    // Configuration register file
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_FAC = 1'd1;

    localparam logic [CFG_DATA_W-1:0] MATCH_TOL_RESET  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] OFFSET_FAC_RESET = 4'd4;

    // Per-row result cap and match counter saturation
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;
    localparam int MC_W        = 4;
    localparam logic [MC_W-1:0] MC_MAX = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic cell_take;
        logic pair_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic need_match;
        logic pair_emit;
        logic pair_last;
        logic pend_valid;
        logic out_busy;
    } stat_t;

endpackage

>>> src/rrmd_ctrl.sv
module rrmd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rrmd_pkg::stat_t stat,
    output rrmd_pkg::cmd_t  cmd
);

    rrmd_pkg::state_t state_reg;
    rrmd_pkg::state_t state_next;

    logic step_ok;

    // A pair that emits waits while both the pending slot and the output are full
    assign step_ok = !(stat.pair_emit && stat.pend_valid && stat.out_busy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrmd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrmd_pkg::ST_IDLE:
            begin
                if (in_valid && stat.need_match)
                begin
                    state_next = rrmd_pkg::ST_MATCH;
                end
            end
            rrmd_pkg::ST_MATCH:
            begin
                if (step_ok && stat.pair_last)
                begin
                    state_next = rrmd_pkg::ST_FLUSH;
                end
            end
            rrmd_pkg::ST_FLUSH:
            begin
                if (!stat.pend_valid || !stat.out_busy)
                begin
                    state_next = rrmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.cell_take = 1'b0;
        cmd.pair_step = 1'b0;
        cmd.flush     = 1'b0;
        case (state_reg)
            rrmd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.cell_take = in_valid;
            end
            rrmd_pkg::ST_MATCH:
            begin
                cmd.pair_step = step_ok;
            end
            rrmd_pkg::ST_FLUSH:
            begin
                cmd.flush = !stat.pend_valid || !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/rrmd_datapath.sv
module rrmd_datapath
#(
    parameter int MAX_RAILS = 8,
    parameter int MAX_CELLS = 512
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [rrmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rrmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [rrmd_pkg::IN_W-1:0]           in_data,
    input  logic                                in_last,
    input  logic                                in_user,
    input  rrmd_pkg::cmd_t                      cmd,
    output rrmd_pkg::stat_t                     stat,
    output logic                                out_valid,
    output logic [rrmd_pkg::OUT_W-1:0]          out_data,
    output logic                                out_last,
    input  logic                                out_ready
);

    localparam int CW = $clog2(MAX_CELLS);
    localparam int RW = $clog2(MAX_RAILS);
    localparam int NW = $clog2(MAX_RAILS + 1);
    localparam int PW = CW + rrmd_pkg::SIZE_W + 1;

    // Configuration
    logic [rrmd_pkg::CFG_DATA_W-1:0] tol_reg;
    logic [rrmd_pkg::CFG_DATA_W-1:0] offset_reg;

    // Row scan state
    logic [CW-1:0] bank_reg [2][MAX_RAILS];
    logic          prev_sel_reg;
    logic [NW-1:0] prev_count_reg;
    logic [NW-1:0] cur_count_reg;
    logic          run_active_reg;
    logic [CW-1:0] run_start_reg;
    logic [CW-1:0] cell_index_reg;

    // Matching state
    logic [rrmd_pkg::MC_W-1:0]    mc_reg [MAX_RAILS];
    logic [RW-1:0]                i_reg;
    logic [RW-1:0]                j_reg;
    logic [NW-1:0]                nbig_reg;
    logic [NW-1:0]                nsmall_reg;
    logic                         big_bank_reg;
    logic                         prev_bigger_reg;
    logic [rrmd_pkg::RES_W-1:0]   n_reg;
    logic [rrmd_pkg::SIZE_W-1:0]  size_reg;
    logic [rrmd_pkg::TOP_W-1:0]   top_reg;
    logic [rrmd_pkg::SHIFT_W-1:0] shift_reg;

    // Pending result and output register
    logic                      pend_valid_reg;
    logic [rrmd_pkg::X_W-1:0]  pend_x_reg;
    logic [rrmd_pkg::Y_W-1:0]  pend_y_reg;
    logic                      out_valid_reg;
    logic [rrmd_pkg::X_W-1:0]  out_x_reg;
    logic [rrmd_pkg::Y_W-1:0]  out_y_reg;
    logic                      out_last_reg;

    // Cell decode
    logic                         occ;
    logic [rrmd_pkg::SIZE_W-1:0]  size_in;
    logic [rrmd_pkg::TOP_W-1:0]   top_in;
    logic [NW-1:0]                cnt;
    logic                         act;
    logic [CW-1:0]                rs;
    logic [CW-1:0]                idx;
    logic [NW-1:0]                pc;
    logic                         run_open;
    logic [CW-1:0]                rs1;
    logic                         close;
    logic [CW:0]                  end_pos;
    logic [CW:0]                  sum;
    logic [CW-1:0]                center;
    logic                         room;
    logic                         wr_ok;
    logic [NW-1:0]                cnt_eff;
    logic                         cur_bank;

    // Pair evaluation
    logic [CW-1:0]               a;
    logic [CW-1:0]               b;
    logic [CW-1:0]               d;
    logic                        hit;
    logic [rrmd_pkg::MC_W-1:0]   mc_inc;
    logic                        emit;
    logic                        j_wrap;
    logic [PW-1:0]               prod;
    logic [rrmd_pkg::X_W-1:0]    new_x;
    logic [rrmd_pkg::Y_W-1:0]    new_y;

    logic push_pair;
    logic push_flush;

    assign occ     = in_data[0];
    assign size_in = in_data[6:1];
    assign top_in  = in_data[18:7];

    // Frame start restarts the row and empties the previous list first
    assign cnt = in_user ? '0 : cur_count_reg;
    assign act = in_user ? 1'b0 : run_active_reg;
    assign rs  = in_user ? '0 : run_start_reg;
    assign idx = in_user ? '0 : cell_index_reg;
    assign pc  = in_user ? '0 : prev_count_reg;

    assign run_open = occ && !act;
    assign rs1      = run_open ? idx : rs;
    // Empty cell closes an open run; an occupied row end closes the run it is in
    assign close    = occ ? in_last : act;
    assign end_pos  = occ ? ({1'b0, idx} + (CW+1)'(1)) : {1'b0, idx};
    assign sum      = {1'b0, rs1} + end_pos;
    assign center   = sum[CW:1];
    assign room     = cnt < NW'(MAX_RAILS);
    assign wr_ok    = close && room;
    assign cnt_eff  = cnt + NW'(wr_ok);
    assign cur_bank = !prev_sel_reg;

    assign a      = bank_reg[big_bank_reg][i_reg];
    assign b      = bank_reg[!big_bank_reg][j_reg];
    assign d      = (a > b) ? (a - b) : (b - a);
    assign hit    = d < CW'(tol_reg);
    assign mc_inc = (mc_reg[j_reg] == rrmd_pkg::MC_MAX) ? mc_reg[j_reg]
                                                       : (mc_reg[j_reg] + 1'b1);
    assign emit   = hit && (mc_inc > rrmd_pkg::MC_W'(1))
                    && (n_reg < rrmd_pkg::RES_W'(rrmd_pkg::MAX_RESULTS));
    assign j_wrap = NW'(j_reg) == (nsmall_reg - NW'(1));

    assign prod  = PW'(b) * PW'(size_reg) + PW'(size_reg >> 1);
    assign new_x = rrmd_pkg::X_W'(prod);
    assign new_y = prev_bigger_reg
                   ? (rrmd_pkg::Y_W'(top_reg) - rrmd_pkg::Y_W'(shift_reg))
                   : (rrmd_pkg::Y_W'(top_reg) + rrmd_pkg::Y_W'(shift_reg));

    assign push_pair  = cmd.pair_step && emit && pend_valid_reg;
    assign push_flush = cmd.flush && pend_valid_reg;

    assign stat.need_match = in_last && (pc != '0) && (cnt_eff != '0) && (pc != cnt_eff);
    assign stat.pair_emit  = emit;
    assign stat.pair_last  = (NW'(i_reg) == (nbig_reg - NW'(1))) && j_wrap;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg         <= rrmd_pkg::MATCH_TOL_RESET;
            offset_reg      <= rrmd_pkg::OFFSET_FAC_RESET;
            prev_sel_reg    <= 1'b0;
            prev_count_reg  <= '0;
            cur_count_reg   <= '0;
            run_active_reg  <= 1'b0;
            run_start_reg   <= '0;
            cell_index_reg  <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            n_reg           <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < MAX_RAILS; k++)
            begin
                mc_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rrmd_pkg::CFG_MATCH_TOL:  tol_reg    <= cfg_data;
                    rrmd_pkg::CFG_OFFSET_FAC: offset_reg <= cfg_data;
                    default:                  tol_reg    <= tol_reg;
                endcase
            end

            if (cmd.cell_take)
            begin
                if (in_last)
                begin
                    prev_count_reg <= cnt_eff;
                    prev_sel_reg   <= !prev_sel_reg;
                    cur_count_reg  <= '0;
                    run_active_reg <= 1'b0;
                    run_start_reg  <= '0;
                    cell_index_reg <= '0;
                end
                else
                begin
                    prev_count_reg <= pc;
                    cur_count_reg  <= cnt_eff;
                    run_active_reg <= occ;
                    run_start_reg  <= rs1;
                    cell_index_reg <= (idx < CW'(MAX_CELLS - 1)) ? (idx + CW'(1)) : idx;
                end
                if (stat.need_match)
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    n_reg <= '0;
                    for (int k = 0; k < MAX_RAILS; k++)
                    begin
                        mc_reg[k] <= '0;
                    end
                end
            end

            if (cmd.pair_step)
            begin
                if (hit)
                begin
                    mc_reg[j_reg] <= mc_inc;
                end
                if (emit)
                begin
                    n_reg          <= n_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                if (j_wrap)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + RW'(1);
                end
                else
                begin
                    j_reg <= j_reg + RW'(1);
                end
            end

            if (push_flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push_pair || push_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cell_take && wr_ok)
        begin
            bank_reg[cur_bank][cnt[RW-1:0]] <= center;
        end

        if (cmd.cell_take && stat.need_match)
        begin
            // Longer list drives the outer loop
            nbig_reg        <= (pc > cnt_eff) ? pc : cnt_eff;
            nsmall_reg      <= (pc > cnt_eff) ? cnt_eff : pc;
            big_bank_reg    <= (pc > cnt_eff) ? prev_sel_reg : cur_bank;
            prev_bigger_reg <= pc > cnt_eff;
            size_reg        <= size_in;
            top_reg         <= top_in;
            shift_reg       <= rrmd_pkg::SHIFT_W'(offset_reg * size_in);
        end

        if (cmd.pair_step && emit)
        begin
            pend_x_reg <= new_x;
            pend_y_reg <= new_y;
        end

        if (push_pair || push_flush)
        begin
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_last_reg <= push_flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{(rrmd_pkg::OUT_W - rrmd_pkg::X_W - rrmd_pkg::Y_W){1'b0}},
                        out_y_reg, out_x_reg};

endmodule

>>> src/rail_run_merge_detector_core.sv
// Channel   | Direction | Signals                                   | Transaction
// ----------+-----------+-------------------------------------------+---------------------------
// s_*       | in        | s_tvalid s_tready s_tdata s_tlast s_tuser | one grid cell
// m_*       | out       | m_tvalid m_tready m_tdata m_tlast         | one crossing point
// cfg_*     | in        | cfg_valid cfg_ready cfg_index cfg_data    | one register write
//
// A row end that triggers matching walks all nbig * nsmall pairs:
// one pair of centres is compared per cycle by the single comparator, then the flush state.
// An emitting pair or the flush waits only while the pending slot and output register are full.
// rst_n is asynchronous, active low; the registers come back as 4 and 4.
// The next cell is taken while the final crossing of a row still waits at the output.
module rail_run_merge_detector_core
#(
    parameter int MAX_RAILS = 8,
    parameter int MAX_CELLS = 512
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rrmd_pkg::IN_W-1:0]       s_tdata,   // occupied, cell_size[5:0], row_top[11:0]
    input  logic                            s_tlast,   // row_end
    input  logic                            s_tuser,   // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrmd_pkg::OUT_W-1:0]      m_tdata,   // cross_x[15:0], cross_y[13:0]
    output logic                            m_tlast,   // last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrmd_pkg::CFG_DATA_W-1:0] cfg_data
);

    rrmd_pkg::cmd_t  cmd;
    rrmd_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    rrmd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrmd_datapath
    #(
        .MAX_RAILS (MAX_RAILS),
        .MAX_CELLS (MAX_CELLS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

endmodule

>>> src/rrmd_checker.sv
module rrmd_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rrmd_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A cell inside a row never starts matching
    a_mid_row_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("input blocked after a mid-row cell");

    // A one-row frame has no previous row to match against
    a_frame_row_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && s_tuser |=> s_tready)
        else $error("matching started on the first row of a frame");

    // Results are produced only while matching holds off the input
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared outside matching");

endmodule

bind rail_run_merge_detector_core rrmd_checker u_rrmd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_RAILS    = 8;
    localparam int MAX_CELLS    = 512;
    localparam int SETTLE_WAIT  = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int ROW_MAP_SIZE = 600;

    typedef struct packed {
        logic                        occupied;
        logic                        row_end;
        logic                        frame_start;
        logic [rrmd_pkg::SIZE_W-1:0] cell_size;
        logic [rrmd_pkg::TOP_W-1:0]  row_top;
    } cell_t;

    typedef struct packed {
        logic [rrmd_pkg::X_W-1:0] x;
        logic [rrmd_pkg::Y_W-1:0] y;
        logic                     last;
    } crossing_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rrmd_pkg::IN_W-1:0]       s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rrmd_pkg::OUT_W-1:0]      m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rrmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rrmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    cell_t     cell_queue[$];
    crossing_t crossing_queue[$];

    // predictor state
    logic [8:0] prev_ctr [MAX_RAILS];
    logic [8:0] cur_ctr [MAX_RAILS];
    int         match_hits [MAX_RAILS];
    int         prev_n = 0;
    int         cur_n = 0;
    bit         run_on = 1'b0;
    int         run_from = 0;
    int         cell_pos = 0;
    int         tol_cfg = int'(rrmd_pkg::MATCH_TOL_RESET);
    int         offset_cfg = int'(rrmd_pkg::OFFSET_FAC_RESET);

    int cells_sent = 0;
    int crossings_predicted = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    bit calm = 1'b0;

    bit row_map [ROW_MAP_SIZE];
    int row_len = 0;

    rail_run_merge_detector_core #(
        .MAX_RAILS (MAX_RAILS),
        .MAX_CELLS (MAX_CELLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void close_run_at(input int end_excl);
        if (cur_n < MAX_RAILS)
        begin
            cur_ctr[cur_n] = 9'((run_from + end_excl) / 2);
            cur_n++;
        end
        run_on = 1'b0;
    endfunction

    // Advance the row state by one cell and queue the crossings it yields
    task automatic take_cell(input cell_t c);
        crossing_t row_out[$];
        crossing_t cr;
        int        idx, n_big, n_small, i, j, a, b, d, shift, yv, xv, size;
        bit        prev_more;

        size = int'(c.cell_size);
        if (c.frame_start)
        begin
            prev_n = 0;
            cur_n = 0;
            run_on = 1'b0;
            run_from = 0;
            cell_pos = 0;
        end
        idx = cell_pos;
        if (c.occupied)
        begin
            if (!run_on)
            begin
                run_on = 1'b1;
                run_from = idx;
            end
        end
        else if (run_on)
        begin
            close_run_at(idx);
        end

        if (c.row_end)
        begin
            if (run_on)
                close_run_at(idx + 1);
            if (prev_n != 0 && prev_n != cur_n)
            begin
                prev_more = prev_n > cur_n;
                n_big = prev_more ? prev_n : cur_n;
                n_small = prev_more ? cur_n : prev_n;
                for (i = 0; i < MAX_RAILS; i++)
                    match_hits[i] = 0;
                shift = offset_cfg * size;
                yv = prev_more ? int'(c.row_top) - shift : int'(c.row_top) + shift;
                for (i = 0; i < n_big; i++)
                begin
                    for (j = 0; j < n_small; j++)
                    begin
                        a = prev_more ? int'(prev_ctr[i]) : int'(cur_ctr[i]);
                        b = prev_more ? int'(cur_ctr[j]) : int'(prev_ctr[j]);
                        d = a > b ? a - b : b - a;
                        if (d < tol_cfg)
                        begin
                            if (match_hits[j] < int'(rrmd_pkg::MC_MAX))
                                match_hits[j]++;
                            if (match_hits[j] > 1 && row_out.size() < rrmd_pkg::MAX_RESULTS)
                            begin
                                xv = b * size + size / 2;
                                cr.x = xv[rrmd_pkg::X_W-1:0];
                                cr.y = yv[rrmd_pkg::Y_W-1:0];
                                cr.last = 1'b0;
                                row_out = {row_out, cr};
                            end
                        end
                    end
                end
                if (row_out.size() > 0)
                    row_out[row_out.size() - 1].last = 1'b1;
                foreach (row_out[k])
                    crossing_queue = {crossing_queue, row_out[k]};
                crossings_predicted += row_out.size();
            end
            for (i = 0; i < cur_n; i++)
                prev_ctr[i] = cur_ctr[i];
            prev_n = cur_n;
            cur_n = 0;
            run_on = 1'b0;
            run_from = 0;
            cell_pos = 0;
        end
        else if (idx + 1 < MAX_CELLS)
        begin
            cell_pos = idx + 1;
        end
    endtask

    // Cell driver
    always @(posedge clk or negedge rst_n)
    begin
        bit    busy;
        cell_t c;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            s_tuser <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                take_cell(cell_queue.pop_front());
                busy = 1'b0;
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 6);
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cell_queue.size() > 0)
                begin
                    c = cell_queue[0];
                    s_tdata <= {5'b0, c.row_top, c.cell_size, c.occupied};
                    s_tlast <= c.row_end;
                    s_tuser <= c.frame_start;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Crossing monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        crossing_t                want;
        logic [rrmd_pkg::X_W-1:0] got_x;
        logic [rrmd_pkg::Y_W-1:0] got_y;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_x = m_tdata[rrmd_pkg::X_W-1:0];
                got_y = m_tdata[rrmd_pkg::X_W+rrmd_pkg::Y_W-1:rrmd_pkg::X_W];
                if (crossing_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected crossing: x=%0d y=%0d last=%0b",
                                 got_x, $signed(got_y), m_tlast);
                end
                else
                begin
                    want = crossing_queue.pop_front();
                    if (got_x !== want.x || got_y !== want.y || m_tlast !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("crossing mismatch: x=%0d/%0d y=%0d/%0d last=%0b/%0b %s",
                                     want.x, got_x, $signed(want.y), $signed(got_y),
                                     want.last, m_tlast, "(expected/actual)");
                    end
                end
            end
            if (hold_served != hold_ticket)
            begin
                hold_served = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [rrmd_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[rrmd_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rrmd_pkg::CFG_MATCH_TOL)
            tol_cfg = value;
        else
            offset_cfg = value;
    endtask

    // Wait until every cell is taken and every crossing is in, then let the block go quiet
    task automatic settle();
        while (cell_queue.size() != 0 || crossing_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic clear_row(input int len);
        int i;
        for (i = 0; i < ROW_MAP_SIZE; i++)
            row_map[i] = 1'b0;
        row_len = len;
    endtask

    task automatic mark_run(input int start, input int len);
        int i;
        for (i = start; i < start + len && i < row_len; i++)
            row_map[i] = 1'b1;
    endtask

    task automatic load_pattern(input string bits);
        int i;
        clear_row(bits.len());
        for (i = 0; i < bits.len(); i++)
            row_map[i] = (bits[i] == "1");
    endtask

    // fs_at: cell carrying frame_start, or -1 for none
    task automatic push_row(input int size, input int top, input int fs_at);
        cell_t c;
        int    i;
        for (i = 0; i < row_len; i++)
        begin
            c.occupied = row_map[i];
            c.row_end = (i == row_len - 1);
            c.frame_start = (i == fs_at);
            c.cell_size = rrmd_pkg::SIZE_W'(size);
            c.row_top = rrmd_pkg::TOP_W'(top);
            cell_queue = {cell_queue, c};
            cells_sent++;
        end
    endtask

    task automatic push_random_row();
        int len, mode, pos, w, k, runs, r, fs;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            // noise
            len = $urandom_range(1, 16);
            clear_row(len);
            for (k = 0; k < len; k++)
                row_map[k] = $urandom_range(0, 1);
        end
        else if (mode == 1)
        begin
            // as many runs as the row list holds, or more
            len = $urandom_range(16, 24);
            clear_row(len);
            for (k = $urandom_range(0, 1); k < len; k += 2)
                row_map[k] = 1'b1;
        end
        else
        begin
            len = $urandom_range(4, 20);
            clear_row(len);
            pos = $urandom_range(0, 2);
            runs = $urandom_range(1, 6);
            for (k = 0; k < runs && pos < len; k++)
            begin
                w = $urandom_range(1, 3);
                mark_run(pos, w);
                pos += w + $urandom_range(1, 3);
            end
            if ($urandom_range(0, 5) == 0)
                row_map[len - 1] = 1'b1;
        end
        r = $urandom_range(0, 19);
        if (r < 3)
            fs = 0;
        else if (r == 3 && len > 1)
            fs = $urandom_range(1, len - 1);
        else
            fs = -1;
        push_row($urandom_range(1, 63), $urandom_range(0, 4095), fs);
    endtask

    task automatic run_rows(input int cell_budget, input int want_crossings);
        int first_cell, first_crossing, rows;
        first_cell = cells_sent;
        first_crossing = crossings_predicted;
        rows = 0;
        while ((cells_sent - first_cell < cell_budget
                || crossings_predicted - first_crossing < want_crossings) && rows < 200)
        begin
            push_random_row();
            rows++;
            // let predictions catch up with the pending cells
            while (cell_queue.size() > 24)
                @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register reset values; size and top extremes, both shift directions
        load_pattern("101011");
        push_row(1, 0, 0);
        load_pattern("011100");
        push_row(63, 0, -1);
        load_pattern("110101");
        push_row(62, 4095, -1);
        load_pattern("10101");
        push_row(33, 2730, -1);
        load_pattern("00");
        push_row(30, 1365, -1);
        load_pattern("1");
        push_row(1, 4095, -1);
        load_pattern("1101");
        push_row(32, 2048, 2);
        settle();

        write_reg(rrmd_pkg::CFG_MATCH_TOL, 1);
        write_reg(rrmd_pkg::CFG_OFFSET_FAC, 0);
        run_rows(30, 0);
        settle();

        // long receiver hold-off while the sender keeps offering cells
        write_reg(rrmd_pkg::CFG_MATCH_TOL, 15);
        write_reg(rrmd_pkg::CFG_OFFSET_FAC, 15);
        hold_ticket++;
        run_rows(70, 20);
        settle();

        write_reg(rrmd_pkg::CFG_MATCH_TOL, $urandom_range(2, 8));
        write_reg(rrmd_pkg::CFG_OFFSET_FAC, $urandom_range(0, 15));
        run_rows(60, 0);
        settle();

        calm = 1'b1;
        write_reg(rrmd_pkg::CFG_MATCH_TOL, 5);
        write_reg(rrmd_pkg::CFG_OFFSET_FAC, 7);
        run_rows(50, 5);
        settle();

        if (fail_count == 0 && crossing_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
